>>> rtl/core/ipl4cs_pkg.sv
// ----------------------------------------------------------------------------
// ipl4cs_pkg
// Shared constants, codes and a helper for the IPv4 transport checksum block.
// ----------------------------------------------------------------------------
package ipl4cs_pkg;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SHORT   = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR = 2'd2;

    // Fixed byte offsets inside the IPv4 header, and the saturating index limit
    localparam logic [15:0] IDX_IHL        = 16'd0;
    localparam logic [15:0] IDX_TLEN_HI    = 16'd2;
    localparam logic [15:0] IDX_TLEN_LO    = 16'd3;
    localparam logic [15:0] IDX_PROTO      = 16'd9;
    localparam logic [15:0] IDX_ADDR_FIRST = 16'd12;
    localparam logic [15:0] IDX_ADDR_LAST  = 16'd19;
    localparam logic [15:0] IDX_MAX        = 16'hffff;

    localparam logic [5:0]  MIN_HEADER_BYTES = 6'd20;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

>>> rtl/core/ipl4cs_in_if.sv
// ----------------------------------------------------------------------------
// ipl4cs_in_if
// Packet byte channel: one byte per beat with a last marker.
// ----------------------------------------------------------------------------
interface ipl4cs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/core/ipl4cs_out_if.sv
// ----------------------------------------------------------------------------
// ipl4cs_out_if
// Result channel: checksum and status, one beat per packet.
// ----------------------------------------------------------------------------
interface ipl4cs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;
    logic [1:0]  status;

    modport source (output valid, output checksum, output status, input ready);
    modport sink   (input valid, input checksum, input status, output ready);
endinterface

>>> rtl/core/ipv4_l4_pseudo_header_checksum.sv
// ----------------------------------------------------------------------------
// ipv4_l4_pseudo_header_checksum
// IPv4 transport checksum (with pseudo header) over a packet byte stream.
// ----------------------------------------------------------------------------
// Flow: a last byte is first registered in the byte stage, then its result is
//   written to the result register, which drives the result beat.
// Throughput: one byte per cycle, back to back across packets; the only stall
//   is a last byte meeting a result register that is full and not drained.
// Reset: i_rst_n synchronous, active low; empties the byte stage and the
//   result register and clears all per-packet state. State also returns to
//   zero after every last byte.
// ----------------------------------------------------------------------------
module ipv4_l4_pseudo_header_checksum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ipl4cs_in_if.sink           i_in,
    ipl4cs_out_if.source        o_out
);
    import ipl4cs_pkg::*;

    // Byte stage: the accepted beat is registered here first.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // Per-packet parsing / sum state
    logic [15:0] r_byte_index,        n_byte_index;
    logic [5:0]  r_header_bytes,      n_header_bytes;
    logic [15:0] r_total_length,      n_total_length;
    logic [15:0] r_running_sum,       n_running_sum;
    logic [7:0]  r_pending_high_byte, n_pending_high_byte;
    logic        r_length_folded,     n_length_folded;

    // Result register
    logic        r_out_valid;
    logic [15:0] r_out_checksum,      n_out_checksum;
    logic [1:0]  r_out_status,        n_out_status;

    logic        stage_adv;   // byte stage may hand its beat on
    logic        stage_fire;  // byte stage is processed this cycle
    logic [15:0] addend;
    logic        do_add;
    logic [15:0] tl_full;     // total length once its low byte is in
    logic [15:0] l4_len;
    logic        header_ok;
    logic [16:0] received;
    logic [15:0] final_sum;

    // ---------------------------------------------------------------------
    // Handshake. A non-last byte never needs the result register, so only a
    // last byte waits on it. Result register drains in the same cycle.
    // ---------------------------------------------------------------------
    assign stage_adv  = !r_in_last || !r_out_valid || o_out.ready;
    assign stage_fire = r_in_valid && stage_adv;
    assign i_in.ready = !r_in_valid || stage_adv;

    assign o_out.valid    = r_out_valid;
    assign o_out.checksum = r_out_checksum;
    assign o_out.status   = r_out_status;

    // ---------------------------------------------------------------------
    // Per-byte state update: header capture, then one ones' complement add.
    // ---------------------------------------------------------------------
    always_comb begin
        n_header_bytes      = r_header_bytes;
        n_total_length      = r_total_length;
        n_pending_high_byte = r_pending_high_byte;
        n_length_folded     = r_length_folded;
        addend              = '0;
        do_add              = 1'b0;
        tl_full             = {r_total_length[15:8], r_in_byte};
        l4_len              = tl_full - {10'd0, r_header_bytes};

        if (r_byte_index == IDX_IHL) begin
            // IHL is in 32-bit words
            n_header_bytes = {r_in_byte[3:0], 2'b00};
        end else if (r_byte_index == IDX_TLEN_HI) begin
            n_total_length = {r_in_byte, 8'h00};
        end else if (r_byte_index == IDX_TLEN_LO) begin
            n_total_length = tl_full;
            // L4 length enters the pseudo header sum only for a sane header
            if (r_header_bytes >= MIN_HEADER_BYTES &&
                tl_full >= {10'd0, r_header_bytes}) begin
                addend          = l4_len;
                do_add          = 1'b1;
                n_length_folded = 1'b1;
            end
        end else if (r_byte_index == IDX_PROTO) begin
            // zero byte + protocol
            addend = {8'h00, r_in_byte};
            do_add = 1'b1;
        end else if (r_byte_index inside {[IDX_ADDR_FIRST:IDX_ADDR_LAST]}) begin
            // source and destination addresses, big-endian words
            if (!r_byte_index[0]) begin
                n_pending_high_byte = r_in_byte;
            end else begin
                addend = {r_pending_high_byte, r_in_byte};
                do_add = 1'b1;
            end
        end else if (r_byte_index >= {10'd0, MIN_HEADER_BYTES} &&
                     r_byte_index >= {10'd0, r_header_bytes} &&
                     r_byte_index <  r_total_length && r_length_folded) begin
            // L4 payload; header length is a multiple of 4 so the word
            // phase follows the index parity directly
            if (!r_byte_index[0]) begin
                n_pending_high_byte = r_in_byte;
            end else begin
                addend = {r_pending_high_byte, r_in_byte};
                do_add = 1'b1;
            end
        end

        n_running_sum = do_add ? oc_add(r_running_sum, addend) : r_running_sum;
        n_byte_index  = (r_byte_index == IDX_MAX) ? r_byte_index : r_byte_index + 16'd1;
    end

    // ---------------------------------------------------------------------
    // Result for a last byte: status checks, odd-length pad, inversion.
    // ---------------------------------------------------------------------
    always_comb begin
        received  = {1'b0, r_byte_index} + 17'd1;
        header_ok = n_header_bytes >= MIN_HEADER_BYTES &&
                    n_total_length >= {10'd0, n_header_bytes};
        // odd L4 length: last high byte pairs with a zero low byte
        final_sum = (n_total_length[0] ^ n_header_bytes[0]) ?
                    oc_add(n_running_sum, {n_pending_high_byte, 8'h00}) :
                    n_running_sum;

        if (r_byte_index < IDX_TLEN_LO) begin
            n_out_status = STATUS_SHORT;          // total length never seen
        end else if (!header_ok) begin
            n_out_status = STATUS_BAD_HDR;
        end else if (received < {1'b0, n_total_length}) begin
            n_out_status = STATUS_SHORT;
        end else begin
            n_out_status = STATUS_OK;
        end

        n_out_checksum = (n_out_status == STATUS_OK) ? ~final_sum : 16'h0000;
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_byte_index        <= '0;
            r_header_bytes      <= '0;
            r_total_length      <= '0;
            r_running_sum       <= '0;
            r_pending_high_byte <= '0;
            r_length_folded     <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end

            if (stage_fire) begin
                if (r_in_last) begin
                    // packet done: back to the reset state
                    r_byte_index        <= '0;
                    r_header_bytes      <= '0;
                    r_total_length      <= '0;
                    r_running_sum       <= '0;
                    r_pending_high_byte <= '0;
                    r_length_folded     <= 1'b0;
                end else begin
                    r_byte_index        <= n_byte_index;
                    r_header_bytes      <= n_header_bytes;
                    r_total_length      <= n_total_length;
                    r_running_sum       <= n_running_sum;
                    r_pending_high_byte <= n_pending_high_byte;
                    r_length_folded     <= n_length_folded;
                end
            end

            if (stage_fire && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (stage_fire && r_in_last) begin
            r_out_checksum <= n_out_checksum;
            r_out_status   <= n_out_status;
        end
    end

endmodule

>>> rtl/core/ipl4cs_checker.sv
// ----------------------------------------------------------------------------
// ipl4cs_checker
// Port-level checks for the IPv4 transport checksum block, bound to its top.
// ----------------------------------------------------------------------------
module ipl4cs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_checksum,
    input logic [1:0]  i_out_status
);
    import ipl4cs_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_checksum) && $stable(i_out_status))
        else $error("result beat changed while stalled");

    // a failed packet carries a zero checksum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != STATUS_OK |-> i_out_checksum == 16'h0000)
        else $error("nonzero checksum with error status");

    // a fresh result beat comes from an earlier accepted last byte
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("result beat without a last byte");

    // input side stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while result side is free");

endmodule

bind ipv4_l4_pseudo_header_checksum ipl4cs_checker u_ipl4cs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_last      (i_in.last_byte),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_checksum (o_out.checksum),
    .i_out_status   (o_out.status)
);

>>> tb/sv/ipv4_l4_pseudo_header_checksum_tb.sv
// ----------------------------------------------------------------------------
// ipv4_l4_pseudo_header_checksum_tb
// Self-checking bench for the IPv4 transport checksum block. Packets are fed
// byte by byte, most with random gaps. A scoreboard recomputes the pseudo-header
// ones' complement sum for every accepted byte and compares each result beat
// with the oldest expected checksum and status.
// ----------------------------------------------------------------------------
module ipv4_l4_pseudo_header_checksum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipl4cs_pkg::*;

typedef struct packed {
    logic [15:0] checksum;
    logic [1:0]  status;
} t_csum_result;

class l4_csum_scoreboard;
    t_csum_result expected_sums[$];
    int           n_errors;

    // per-packet state, cleared after every last byte
    logic [15:0] byte_idx;
    logic [5:0]  hdr_bytes;
    logic [15:0] tot_len;
    logic [15:0] run_sum;
    logic [7:0]  hi_byte;
    logic        len_folded;

    function new();
        n_errors = 0;
        clear_packet();
    endfunction

    function void clear_packet();
        byte_idx   = '0;
        hdr_bytes  = '0;
        tot_len    = '0;
        run_sum    = '0;
        hi_byte    = '0;
        len_folded = 1'b0;
    endfunction

    function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function void note_failure(string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // One accepted input beat; queues a result when it carries the last mark.
    function void take_byte(logic [7:0] b, logic last);
        logic [15:0]  idx;
        logic [16:0]  rcvd;
        logic         hdr_ok;
        logic [15:0]  sum;
        logic [15:0]  l4_len;
        t_csum_result res;
        idx = byte_idx;
        if (idx == IDX_IHL) begin
            hdr_bytes = {b[3:0], 2'b00};
        end else if (idx == IDX_TLEN_HI) begin
            tot_len = {b, 8'h00};
        end else if (idx == IDX_TLEN_LO) begin
            tot_len[7:0] = b;
            if (hdr_bytes >= MIN_HEADER_BYTES && tot_len >= {10'd0, hdr_bytes}) begin
                run_sum    = ones_add(run_sum, tot_len - {10'd0, hdr_bytes});
                len_folded = 1'b1;
            end
        end else if (idx == IDX_PROTO) begin
            run_sum = ones_add(run_sum, {8'h00, b});
        end else if (idx >= IDX_ADDR_FIRST && idx <= IDX_ADDR_LAST) begin
            if (!idx[0])
                hi_byte = b;
            else
                run_sum = ones_add(run_sum, {hi_byte, b});
        end else if (idx >= {10'd0, MIN_HEADER_BYTES} && idx >= {10'd0, hdr_bytes}
                     && idx < tot_len && len_folded) begin
            l4_len = idx - {10'd0, hdr_bytes};
            if (!l4_len[0])
                hi_byte = b;
            else
                run_sum = ones_add(run_sum, {hi_byte, b});
        end

        if (byte_idx != IDX_MAX)
            byte_idx++;

        if (last) begin
            rcvd   = {1'b0, idx} + 17'd1;
            hdr_ok = hdr_bytes >= MIN_HEADER_BYTES && tot_len >= {10'd0, hdr_bytes};
            if (rcvd < 17'd4)
                res.status = STATUS_SHORT;
            else if (!hdr_ok)
                res.status = STATUS_BAD_HDR;
            else if (rcvd < {1'b0, tot_len})
                res.status = STATUS_SHORT;
            else
                res.status = STATUS_OK;
            res.checksum = '0;
            if (res.status == STATUS_OK) begin
                sum    = run_sum;
                l4_len = tot_len - {10'd0, hdr_bytes};
                // odd L4 length: last byte padded with a zero low byte
                if (l4_len[0])
                    sum = ones_add(sum, {hi_byte, 8'h00});
                res.checksum = ~sum;
            end
            expected_sums.push_back(res);
            clear_packet();
        end
    endfunction

    function void check_result(logic [15:0] cs, logic [1:0] st);
        t_csum_result exp_res;
        if (expected_sums.size() == 0) begin
            note_failure($sformatf("unexpected result beat: checksum %h status %0d", cs, st));
            return;
        end
        exp_res = expected_sums.pop_front();
        if (cs !== exp_res.checksum || st !== exp_res.status)
            note_failure($sformatf("result mismatch: expected checksum %h status %0d, got %h %0d",
                                   exp_res.checksum, exp_res.status, cs, st));
    endfunction

    function int pending();
        return expected_sums.size();
    endfunction

    function void flush_leftovers();
        while (expected_sums.size() != 0) begin
            note_failure($sformatf("result never arrived: checksum %h status %0d",
                                   expected_sums[0].checksum, expected_sums[0].status));
            void'(expected_sums.pop_front());
        end
    endfunction
endclass

    // The limit sits well above the worst correct run: at least RAND_BYTES random
    // bytes, each possibly after a random gap, plus result stalls and drains.
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned RAND_BYTES  = 1300;
    localparam int unsigned MIN_PACKETS = 40;

    typedef enum int {
        PK_GOOD,     // well-formed header, total length matches the stream
        PK_TRUNC,    // well-formed header, stream ends early
        PK_TRAIL,    // well-formed header, extra bytes past total length
        PK_BADLEN,   // header length below 20 or total length below header
        PK_NOISE     // random bytes of random length
    } t_pkt_kind;

    logic clk;
    logic rst_n;

    ipl4cs_in_if  byte_if ();
    ipl4cs_out_if sum_if ();

    ipv4_l4_pseudo_header_checksum u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_if),
        .o_out   (sum_if)
    );

    l4_csum_scoreboard sb = new();

    logic [7:0]  pkt[$];          // packet under construction
    int unsigned n_bytes_taken;   // input beats seen by the monitor
    int unsigned n_results_taken; // result beats seen by the monitor
    int unsigned n_sent_bytes;
    int unsigned n_packets;
    int unsigned cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: both channels sampled at the rising edge. Results are checked
    // before the same-edge byte is noted; latency keeps them unrelated anyway.
    always @(posedge clk) begin
        if (rst_n) begin
            if (sum_if.valid && sum_if.ready) begin
                sb.check_result(sum_if.checksum, sum_if.status);
                n_results_taken++;
            end
            if (byte_if.valid && byte_if.ready) begin
                sb.take_byte(byte_if.data_byte, byte_if.last_byte);
                n_bytes_taken++;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stall before each beat, with stall-free stretches.
    initial begin
        int unsigned gap;
        int unsigned seen;
        bit          stalls_on;
        sum_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stalls_on = ($urandom_range(0, 3) != 0);
            if (stalls_on) begin
                gap = $urandom_range(0, 15);
                if (gap != 0) begin
                    sum_if.ready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            sum_if.ready = 1'b1;
            seen = n_results_taken;
            @(negedge clk);
            while (n_results_taken == seen)
                @(negedge clk);
        end
    end

    // Biased byte: extremes show up often so carries and 0xff words get hit.
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void build_packet(t_pkt_kind kind);
        int unsigned ihl;
        int unsigned hdr;
        int unsigned l4;
        int unsigned tlen;
        int unsigned n;
        pkt.delete();
        if (kind == PK_NOISE) begin
            n = $urandom_range(1, 40);
            repeat (n) pkt.push_back(pick_byte());
            return;
        end
        ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        hdr  = ihl * 4;
        l4   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
        tlen = hdr + l4;
        n    = tlen;
        if (kind == PK_BADLEN) begin
            if ($urandom_range(0, 1) == 0) begin
                ihl  = $urandom_range(0, 4);
                tlen = $urandom_range(0, 65535);
            end else begin
                tlen = $urandom_range(0, hdr - 1);
            end
            n = $urandom_range(4, 30);
        end
        // version nibble is don't-care for the block, so randomize it
        pkt.push_back({4'($urandom_range(0, 15)), 4'(ihl)});
        pkt.push_back(pick_byte());
        pkt.push_back(8'(tlen >> 8));
        pkt.push_back(8'(tlen));
        while (pkt.size() < n)
            pkt.push_back(pick_byte());
        if (kind == PK_TRUNC) begin
            n = $urandom_range(1, tlen - 1);
            while (pkt.size() > n)
                void'(pkt.pop_back());
        end else if (kind == PK_TRAIL) begin
            repeat ($urandom_range(1, 4)) pkt.push_back(pick_byte());
        end
    endfunction

    // Feeds pkt, last mark on the final byte; each beat is held until taken.
    task automatic send_packet(bit gaps_on);
        int unsigned k;
        int unsigned gap;
        int unsigned seen;
        for (k = 0; k < pkt.size(); k++) begin
            if (gaps_on) begin
                gap = $urandom_range(0, 15);
                if (gap != 0) begin
                    byte_if.valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            byte_if.valid     = 1'b1;
            byte_if.data_byte = pkt[k];
            byte_if.last_byte = (k == pkt.size() - 1);
            seen = n_bytes_taken;
            @(negedge clk);
            while (n_bytes_taken == seen)
                @(negedge clk);
        end
        byte_if.valid = 1'b0;
        n_sent_bytes += pkt.size();
        n_packets++;
    endtask

    // Hold the byte side off until every queued result has come back.
    task automatic wait_results_drained();
        byte_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial begin
        int unsigned r;
        t_pkt_kind   kind;
        rst_n             = 1'b0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = 8'h00;
        byte_if.last_byte = 1'b0;
        n_bytes_taken     = 0;
        n_results_taken   = 0;
        n_sent_bytes      = 0;
        n_packets         = 0;
        cycles            = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed ---
        // single byte: total length never arrives, short
        pkt = '{8'hff};
        send_packet(1'b1);
        // three bytes: still short
        pkt = '{8'h45, 8'h00, 8'h00};
        send_packet(1'b0);
        // IHL 4 gives 16 header bytes: bad header, wins over short
        pkt = '{8'h44, 8'h00, 8'h00, 8'h14};
        send_packet(1'b1);
        // bare 20-byte header, zero protocol and addresses: sum stays zero,
        // so the checksum comes out as 0xffff
        pkt = '{8'h45, 8'h00, 8'h00, 8'h14};
        repeat (16) pkt.push_back(8'h00);
        send_packet(1'b0);

        wait_results_drained();

        // --- random ---
        while (n_sent_bytes < RAND_BYTES || n_packets < MIN_PACKETS) begin
            r = $urandom_range(0, 99);
            if (r < 65)
                kind = PK_GOOD;
            else if (r < 75)
                kind = PK_TRUNC;
            else if (r < 83)
                kind = PK_TRAIL;
            else if (r < 90)
                kind = PK_BADLEN;
            else
                kind = PK_NOISE;
            build_packet(kind);
            send_packet($urandom_range(0, 3) != 0);
        end

        // --- wind down ---
        wait_results_drained();
        repeat (10) @(negedge clk);   // catch any stray beat
        sb.flush_leftovers();
        if (sb.n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ipl4cs_pkg.sv
rtl/core/ipl4cs_in_if.sv
rtl/core/ipl4cs_out_if.sv
rtl/core/ipv4_l4_pseudo_header_checksum.sv
rtl/core/ipl4cs_checker.sv
tb/sv/ipv4_l4_pseudo_header_checksum_tb.sv
